// ===== hdl/tre_pkg.sv =====
// shared types and codes for the timestamp rank enumerator
// used by tre_cell and timestamp_rank_enumerator; no dependencies
package tre_pkg;

   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ACT_ADD      = 2'd0,
      ACT_ENUM     = 2'd1,
      ACT_ENUM_ALL = 2'd2,
      ACT_NONE     = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      RS_ADDED      = 3'd0,
      RS_NO_FIELD   = 3'd1,
      RS_FULL       = 3'd2,
      RS_ENUMERATED = 3'd3,
      RS_EMPTY      = 3'd4
   } status_type;

   typedef enum logic {
      CSR_BASE_TIME = 1'b0,
      CSR_INTERVAL  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DROP   = 2'd2,
      OP_ROTATE = 2'd3
   } cell_op_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   // where a cell stands relative to the fill level
   typedef struct packed {
      logic occupied;
      logic at_fill;
      logic at_tail;
   } cell_pos_type;

endpackage

// ===== hdl/tre_cell.sv =====
// one slot of the ordered record chain: holds a sequence number and timestamp
// depends on tre_pkg
module tre_cell (
   input  logic                 clock,
   input  tre_pkg::cell_op_type op,
   input  tre_pkg::cell_pos_type pos,
   input  logic [31:0]          new_seq,
   input  logic [31:0]          new_time,
   input  logic                 left_greater,
   input  logic [31:0]          left_seq,
   input  logic [31:0]          left_time,
   input  logic [31:0]          right_seq,
   input  logic [31:0]          right_time,
   input  logic [31:0]          wrap_seq,
   input  logic [31:0]          wrap_time,
   output logic [31:0]          seq,
   output logic [31:0]          stamp,
   output logic                 greater
);
   import tre_pkg::*;

   logic [31:0] seq_ff, seq_in;
   logic [31:0] time_ff, time_in;

   assign greater = pos.occupied && (time_ff > new_time);
   assign seq     = seq_ff;
   assign stamp   = time_ff;

   always_comb begin
      seq_in  = seq_ff;
      time_in = time_ff;
      unique case (op)
         OP_INSERT: begin
            priority if (left_greater) begin
               seq_in  = left_seq;
               time_in = left_time;
            end else if (greater || pos.at_fill) begin
               seq_in  = new_seq;
               time_in = new_time;
            end
         end
         OP_DROP: begin
            seq_in  = right_seq;
            time_in = right_time;
         end
         OP_ROTATE: begin
            if (pos.at_tail) begin
               seq_in  = wrap_seq;
               time_in = wrap_time;
            end else begin
               seq_in  = right_seq;
               time_in = right_time;
            end
         end
         OP_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      seq_ff  <= seq_in;
      time_ff <= time_in;
   end

endmodule

// ===== hdl/timestamp_rank_enumerator.sv =====
// top level: controller and chain of record cells kept in timestamp order
// depends on tre_pkg and tre_cell
// add: one transaction per cycle while the output is free; result registered and
// valid in the cycle after acceptance. enumerate: a scan state rotates the chain
// (skipped for enumerate-all), then one result per cycle while the output is free
// as the head cell is released or rotated; empty buffer answers in the next cycle
// reset (synchronous): buffer empty, counter 0, interval 1, awaited number cleared
module timestamp_rank_enumerator #(
   parameter int DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_seq_num,
   input  logic [31:0] req_timestamp,
   input  logic        req_field_present,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_record_seq,
   output logic [31:0] rsp_new_value,
   output logic [31:0] rsp_next_lowest,
   output logic        rsp_last,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   import tre_pkg::*;

   localparam int FW = $clog2(DEPTH + 1);

   state_type   state_ff, state_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [31:0] counter_ff, counter_in;
   logic [31:0] interval_ff, interval_in;
   logic [31:0] awaited_ff, awaited_in;
   logic        awaited_valid_ff, awaited_valid_in;
   logic [FW-1:0] cnt_ff, cnt_in;
   logic        found_ff, found_in;
   logic [FW-1:0] stop_ff, stop_in;
   logic [31:0] min_ff, min_in;
   logic [31:0] nl_ff, nl_in;
   logic [FW-1:0] n_ff, n_in;
   logic        drop_ff, drop_in;
   logic        all_ff, all_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_seq_ff, rsp_seq_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic [31:0] rsp_nl_ff, rsp_nl_in;
   logic        rsp_last_ff, rsp_last_in;

   cell_op_type op;
   logic        out_free;
   logic        req_accept;
   logic        scan_found, scan_done, emit_last;
   logic [FW-1:0] scan_stop;
   logic [31:0] scan_min;

   logic [31:0] seq_w   [DEPTH];
   logic [31:0] time_w  [DEPTH];
   logic        greater_w [DEPTH];

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         cell_pos_type pos;
         assign pos.occupied = FW'(i) < fill_ff;
         assign pos.at_fill  = fill_ff == FW'(i);
         assign pos.at_tail  = fill_ff == FW'(i + 1);
         tre_cell u_cell (
            .clock        (clock),
            .op           (op),
            .pos          (pos),
            .new_seq      (req_seq_num),
            .new_time     (req_timestamp),
            .left_greater ((i == 0) ? 1'b0 : greater_w[(i == 0) ? 0 : i - 1]),
            .left_seq     (seq_w[(i == 0) ? 0 : i - 1]),
            .left_time    (time_w[(i == 0) ? 0 : i - 1]),
            .right_seq    (seq_w[(i == DEPTH - 1) ? i : i + 1]),
            .right_time   (time_w[(i == DEPTH - 1) ? i : i + 1]),
            .wrap_seq     (seq_w[0]),
            .wrap_time    (time_w[0]),
            .seq          (seq_w[i]),
            .stamp        (time_w[i]),
            .greater      (greater_w[i])
         );
      end
   endgenerate

   // scan step on the head cell
   always_comb begin
      scan_found = found_ff;
      scan_stop  = stop_ff;
      scan_min   = min_ff;
      if (!found_ff && (seq_w[0] == awaited_ff)) begin
         scan_found = 1'b1;
         scan_stop  = cnt_ff + 1'b1;
      end else if (found_ff && (seq_w[0] < min_ff)) begin
         scan_min = seq_w[0];
      end
   end

   assign scan_done = cnt_ff == (fill_ff - 1'b1);
   assign emit_last = (cnt_ff + 1'b1) == n_ff;

   always_comb begin
      state_in         = state_ff;
      fill_in          = fill_ff;
      counter_in       = counter_ff;
      interval_in      = interval_ff;
      awaited_in       = awaited_ff;
      awaited_valid_in = awaited_valid_ff;
      cnt_in           = cnt_ff;
      found_in         = found_ff;
      stop_in          = stop_ff;
      min_in           = min_ff;
      nl_in            = nl_ff;
      n_in             = n_ff;
      drop_in          = drop_ff;
      all_in           = all_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_status_in    = rsp_status_ff;
      rsp_seq_in       = rsp_seq_ff;
      rsp_value_in     = rsp_value_ff;
      rsp_nl_in        = rsp_nl_ff;
      rsp_last_in      = rsp_last_ff;
      op               = OP_HOLD;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_BASE_TIME: counter_in = csr_data;
            CSR_INTERVAL: interval_in = csr_data;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_action)
                  ACT_ADD: begin
                     rsp_valid_in = 1'b1;
                     rsp_seq_in   = req_seq_num;
                     rsp_value_in = '0;
                     rsp_nl_in    = '0;
                     rsp_last_in  = 1'b1;
                     priority if (!req_field_present) begin
                        rsp_status_in = RS_NO_FIELD;
                     end else if (fill_ff >= FW'(DEPTH)) begin
                        rsp_status_in = RS_FULL;
                     end else begin
                        rsp_status_in = RS_ADDED;
                        op            = OP_INSERT;
                        fill_in       = fill_ff + 1'b1;
                        if (!awaited_valid_ff) begin
                           awaited_in       = req_seq_num;
                           awaited_valid_in = 1'b1;
                        end
                     end
                  end
                  ACT_ENUM, ACT_ENUM_ALL: begin
                     if (fill_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = RS_EMPTY;
                        rsp_seq_in    = '0;
                        rsp_value_in  = '0;
                        rsp_nl_in     = (req_action == ACT_ENUM) ? awaited_ff : ALL_ONES;
                        rsp_last_in   = 1'b1;
                     end else if (req_action == ACT_ENUM) begin
                        if (awaited_ff == ALL_ONES) awaited_in = seq_w[0];
                        state_in = ST_SCAN;
                        all_in   = 1'b0;
                        cnt_in   = '0;
                        found_in = 1'b0;
                        min_in   = ALL_ONES;
                     end else begin
                        state_in = ST_EMIT;
                        all_in   = 1'b1;
                        drop_in  = 1'b1;
                        nl_in    = ALL_ONES;
                        n_in     = fill_ff;
                        cnt_in   = '0;
                     end
                  end
                  ACT_NONE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            op       = OP_ROTATE;
            found_in = scan_found;
            stop_in  = scan_stop;
            min_in   = scan_min;
            cnt_in   = cnt_ff + 1'b1;
            if (scan_done) begin
               state_in = ST_EMIT;
               cnt_in   = '0;
               n_in     = scan_found ? scan_stop : fill_ff;
               nl_in    = scan_found ? scan_min : awaited_ff;
               drop_in  = scan_found;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = RS_ENUMERATED;
               rsp_seq_in    = seq_w[0];
               rsp_value_in  = counter_ff;
               rsp_nl_in     = nl_ff;
               rsp_last_in   = emit_last;
               counter_in    = counter_ff + interval_ff;
               cnt_in        = cnt_ff + 1'b1;
               if (drop_ff) begin
                  op      = OP_DROP;
                  fill_in = fill_ff - 1'b1;
               end else begin
                  op = OP_ROTATE;
               end
               if (emit_last) begin
                  state_in = ST_IDLE;
                  if (!all_ff && drop_ff) awaited_in = nl_ff;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         fill_ff          <= '0;
         counter_ff       <= '0;
         interval_ff      <= 32'd1;
         awaited_ff       <= '0;
         awaited_valid_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         cnt_ff           <= '0;
         found_ff         <= 1'b0;
         drop_ff          <= 1'b0;
         all_ff           <= 1'b0;
      end else begin
         state_ff         <= state_in;
         fill_ff          <= fill_in;
         counter_ff       <= counter_in;
         interval_ff      <= interval_in;
         awaited_ff       <= awaited_in;
         awaited_valid_ff <= awaited_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         cnt_ff           <= cnt_in;
         found_ff         <= found_in;
         drop_ff          <= drop_in;
         all_ff           <= all_in;
      end
   end

   always_ff @(posedge clock) begin
      stop_ff       <= stop_in;
      min_ff        <= min_in;
      nl_ff         <= nl_in;
      n_ff          <= n_in;
      rsp_status_ff <= rsp_status_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_nl_ff     <= rsp_nl_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_record_seq  = rsp_seq_ff;
   assign rsp_new_value   = rsp_value_ff;
   assign rsp_next_lowest = rsp_nl_ff;
   assign rsp_last        = rsp_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(DEPTH))
      else $error("fill level beyond buffer depth");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (fill_ff != '0))
      else $error("emitting from an empty buffer");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("transaction accepted while enumerating");

   a_add_fills: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_action == ACT_ADD) && req_field_present
       && (fill_ff < FW'(DEPTH)) && !csr_write_en)
      |=> (fill_ff == $past(fill_ff) + 1'b1))
      else $error("stored record not counted");

endmodule

// ===== sim/tre_checker.sv =====
// result checker for timestamp_rank_enumerator: watches the request, result and csr ports,
// keeps its own ordered copy of the record buffer and compares every result field by field
// depends on tre_pkg
module tre_checker #(
   parameter int DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_seq_num,
   input  logic [31:0] req_timestamp,
   input  logic        req_field_present,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [31:0] rsp_record_seq,
   input  logic [31:0] rsp_new_value,
   input  logic [31:0] rsp_next_lowest,
   input  logic        rsp_last,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          due_count
);
   import tre_pkg::*;

   typedef struct packed {
      status_type  status;
      logic [31:0] record_seq;
      logic [31:0] new_value;
      logic [31:0] next_lowest;
      logic        last;
   } outcome_type;

   outcome_type outcomes_due[$];
   outcome_type head;

   logic [31:0] slot_seq [DEPTH];
   logic [31:0] slot_time [DEPTH];
   int          held;
   logic [31:0] counter;
   logic [31:0] step;
   logic [31:0] awaited;
   logic        awaited_valid;

   task automatic due(input status_type status, input logic [31:0] seq, value, lowest,
                      input logic last);
      outcome_type o;
      o.status      = status;
      o.record_seq  = seq;
      o.new_value   = value;
      o.next_lowest = lowest;
      o.last        = last;
      outcomes_due = {outcomes_due, o};
   endtask

   task automatic compare_field(input string name, input logic [31:0] want, got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // ordered insert, or numbering walk with prefix release
   task automatic rank_request(input action_type act, input logic [31:0] seq, ts,
                               input logic present);
      int          pos;
      int          stop;
      int          i;
      logic        found;
      logic [31:0] lowest;
      if (act == ACT_ADD) begin
         if (!present) begin
            due(RS_NO_FIELD, seq, '0, '0, 1'b1);
         end else if (held >= DEPTH) begin
            due(RS_FULL, seq, '0, '0, 1'b1);
         end else begin
            pos = held;
            while (pos > 0 && slot_time[pos - 1] > ts) begin
               slot_seq[pos]  = slot_seq[pos - 1];
               slot_time[pos] = slot_time[pos - 1];
               pos--;
            end
            slot_seq[pos]  = seq;
            slot_time[pos] = ts;
            held++;
            if (!awaited_valid) begin
               awaited       = seq;
               awaited_valid = 1'b1;
            end
            due(RS_ADDED, seq, '0, '0, 1'b1);
         end
      end else if (act == ACT_NONE) begin
      end else if (held == 0) begin
         due(RS_EMPTY, '0, '0, (act == ACT_ENUM) ? awaited : ALL_ONES, 1'b1);
      end else begin
         found  = 1'b0;
         stop   = held;
         lowest = ALL_ONES;
         if (act == ACT_ENUM) begin
            if (awaited == ALL_ONES) awaited = slot_seq[0];
            for (i = 0; i < held; i++) begin
               if (!found && slot_seq[i] == awaited) begin
                  found = 1'b1;
                  stop  = i + 1;
               end
            end
            lowest = awaited;
            if (found) begin
               lowest = ALL_ONES;
               for (i = stop; i < held; i++)
                  if (slot_seq[i] < lowest) lowest = slot_seq[i];
            end
         end
         for (i = 0; i < stop; i++) begin
            due(RS_ENUMERATED, slot_seq[i], counter, lowest, i == stop - 1);
            counter = counter + step;
         end
         if (act == ACT_ENUM_ALL) begin
            held = 0;
         end else if (found) begin
            awaited = lowest;
            for (i = stop; i < held; i++) begin
               slot_seq[i - stop]  = slot_seq[i];
               slot_time[i - stop] = slot_time[i];
            end
            held = held - stop;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held          = 0;
         counter       = '0;
         step          = 32'd1;
         awaited       = '0;
         awaited_valid = 1'b0;
         fail_count    = 0;
         outcomes_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outcomes_due.size() == 0) begin
               $display("%0t: unrequested transaction status %0d seq %h value %h lowest %h last %b",
                        $time, rsp_status, rsp_record_seq, rsp_new_value, rsp_next_lowest,
                        rsp_last);
               fail_count++;
            end else begin
               head = outcomes_due.pop_front();
               compare_field("status", head.status, rsp_status);
               compare_field("record_seq", head.record_seq, rsp_record_seq);
               compare_field("new_value", head.new_value, rsp_new_value);
               compare_field("next_lowest", head.next_lowest, rsp_next_lowest);
               compare_field("last", head.last, rsp_last);
            end
         end
         if (csr_write_en) begin
            if (csr_index == CSR_BASE_TIME) counter = csr_data;
            else step = csr_data;
         end
         if (req_valid && !req_stall)
            rank_request(action_type'(req_action), req_seq_num, req_timestamp,
                         req_field_present);
      end
      due_count = outcomes_due.size();
   end

endmodule

// ===== sim/tb.sv =====
// testbench top for timestamp_rank_enumerator: drives requests, csr writes and result stalls,
// and gives the verdict from the failure and due counts of tre_checker
// depends on tre_pkg, tre_checker and the design
module tb;
   import tre_pkg::*;

   localparam int DEPTH       = 32;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [31:0] req_seq_num;
   logic [31:0] req_timestamp;
   logic        req_field_present;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_record_seq;
   logic [31:0] rsp_new_value;
   logic [31:0] rsp_next_lowest;
   logic        rsp_last;
   logic        csr_write_en;
   logic        csr_index;
   logic [31:0] csr_data;
   int          fail_count;
   int          due_count;
   int          cycle_count;
   logic        idling   = 1'b1;
   logic [31:0] next_seq = 32'd100;
   logic [31:0] ts_floor = 32'd0;

   timestamp_rank_enumerator #(.DEPTH(DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_seq_num       (req_seq_num),
      .req_timestamp     (req_timestamp),
      .req_field_present (req_field_present),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_record_seq    (rsp_record_seq),
      .rsp_new_value     (rsp_new_value),
      .rsp_next_lowest   (rsp_next_lowest),
      .rsp_last          (rsp_last),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   tre_checker #(.DEPTH(DEPTH)) rank_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_seq_num       (req_seq_num),
      .req_timestamp     (req_timestamp),
      .req_field_present (req_field_present),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_record_seq    (rsp_record_seq),
      .rsp_new_value     (rsp_new_value),
      .rsp_next_lowest   (rsp_next_lowest),
      .rsp_last          (rsp_last),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .fail_count        (fail_count),
      .due_count         (due_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) rsp_stall <= idling && ($urandom_range(0, 99) < 33);

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic send_req(input action_type act, input logic [31:0] seq, ts,
                           input logic present);
      while (idling && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_seq_num       <= seq;
      req_timestamp     <= ts;
      req_field_present <= present;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // all results in, then room for a walk that gave no result
   task automatic quiesce();
      req_valid <= 1'b0;
      while (due_count != 0) @(negedge clock);
      repeat (DEPTH + 8) @(negedge clock);
   endtask

   // mostly rising sequence numbers, some repeats and some wild values
   function automatic logic [31:0] pick_seq();
      logic [31:0] seq;
      case ($urandom_range(0, 19))
         0, 1, 2: seq = $urandom;
         3, 4, 5: seq = next_seq - $urandom_range(0, 8);
         default: begin
            seq      = next_seq;
            next_seq = next_seq + 1;
         end
      endcase
      return seq;
   endfunction

   // clustered timestamps for ties and reordering, plus extremes
   function automatic logic [31:0] pick_ts();
      logic [31:0] ts;
      ts_floor = ts_floor + $urandom_range(0, 3);
      case ($urandom_range(0, 9))
         0:       ts = 32'd0;
         1:       ts = ALL_ONES;
         2, 3:    ts = $urandom;
         default: ts = ts_floor + $urandom_range(0, 15);
      endcase
      return ts;
   endfunction

   task automatic random_request(input int add_pct);
      int         pick;
      action_type act;
      pick = $urandom_range(0, 99);
      if (pick < add_pct) act = ACT_ADD;
      else if (pick >= 98) act = ACT_NONE;
      else if (pick >= 94) act = ACT_ENUM_ALL;
      else act = ACT_ENUM;
      send_req(act, pick_seq(), pick_ts(), $urandom_range(0, 9) != 0);
   endtask

   initial begin
      int          phase;
      int          add_pct;
      logic [31:0] base;
      logic [31:0] step;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_action        = ACT_ADD;
      req_seq_num       = '0;
      req_timestamp     = '0;
      req_field_present = 1'b0;
      csr_write_en      = 1'b0;
      csr_index         = CSR_BASE_TIME;
      csr_data          = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty buffer with reset settings
      send_req(ACT_ENUM, $urandom, $urandom, 1'b1);
      send_req(ACT_ENUM_ALL, $urandom, $urandom, 1'b0);
      quiesce();
      write_csr(CSR_BASE_TIME, 32'hFFFF_FFFE);
      write_csr(CSR_INTERVAL, 32'd1);

      // rejection, ties, all-ones awaited number, ignored action
      send_req(ACT_ADD, 32'd5, 32'd1, 1'b0);
      send_req(ACT_ADD, ALL_ONES, 32'd100, 1'b1);
      send_req(ACT_ADD, 32'd7, 32'd0, 1'b1);
      send_req(ACT_ADD, 32'd3, 32'd100, 1'b1);
      send_req(ACT_ADD, 32'd0, ALL_ONES, 1'b1);
      send_req(ACT_NONE, $urandom, $urandom, 1'b1);
      send_req(ACT_ENUM, $urandom, $urandom, 1'b1);
      send_req(ACT_ENUM, $urandom, $urandom, 1'b0);
      // awaited record released by enumerate-all, then absent
      send_req(ACT_ADD, 32'd10, 32'd1, 1'b1);
      send_req(ACT_ADD, 32'd11, 32'd2, 1'b1);
      send_req(ACT_ENUM, $urandom, $urandom, 1'b1);
      send_req(ACT_ENUM_ALL, $urandom, $urandom, 1'b1);
      send_req(ACT_ADD, 32'd12, 32'd3, 1'b1);
      send_req(ACT_ENUM, $urandom, $urandom, 1'b1);
      send_req(ACT_ENUM_ALL, $urandom, $urandom, 1'b1);
      send_req(ACT_ENUM, $urandom, $urandom, 1'b1);

      for (phase = 0; phase < 5; phase++) begin
         quiesce();
         case (phase)
            0: begin
               base    = 32'd0;
               step    = ALL_ONES;
               add_pct = 55;
            end
            1: begin
               base    = $urandom;
               step    = $urandom;
               add_pct = 65;
            end
            2: begin
               base    = ALL_ONES;
               step    = 32'd0;
               add_pct = 55;
            end
            3: begin
               base    = $urandom;
               step    = $urandom_range(1, 16);
               add_pct = 70;
            end
            default: begin
               base    = 32'd12345;
               step    = 32'd3;
               add_pct = 60;
            end
         endcase
         write_csr(CSR_BASE_TIME, base);
         write_csr(CSR_INTERVAL, step);
         idling = (phase != 1);
         if (phase == 0) begin
            // run the buffer past full
            repeat (DEPTH + 4) send_req(ACT_ADD, pick_seq(), pick_ts(), 1'b1);
            send_req(ACT_ADD, pick_seq(), pick_ts(), 1'b0);
         end
         repeat (48) random_request(add_pct);
      end

      quiesce();
      if (fail_count == 0 && due_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/tre_pkg.sv
hdl/tre_cell.sv
hdl/timestamp_rank_enumerator.sv
sim/tre_checker.sv
sim/tb.sv
